@@ rtl/acsd_pkg.sv @@
// Shared types and constants for the hard-disk command decoder.
package acsd_pkg;

  // Operation codes.
  localparam logic [7:0] OP_TEST_READY   = 8'h00;
  localparam logic [7:0] OP_REQ_SENSE    = 8'h03;
  localparam logic [7:0] OP_FORMAT       = 8'h04;
  localparam logic [7:0] OP_READ6        = 8'h08;
  localparam logic [7:0] OP_WRITE6       = 8'h0a;
  localparam logic [7:0] OP_INQUIRY      = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE   = 8'h1a;
  localparam logic [7:0] OP_READ_CAP     = 8'h25;
  localparam logic [7:0] OP_READ10       = 8'h28;
  localparam logic [7:0] OP_WRITE10      = 8'h2a;

  // Additional sense codes.
  localparam logic [7:0] ASC_NONE        = 8'h00;
  localparam logic [7:0] ASC_OPCODE      = 8'h20;
  localparam logic [7:0] ASC_RANGE       = 8'h21;
  localparam logic [7:0] ASC_LUN         = 8'h25;

  // Response lengths in 16-bit words.
  localparam logic [7:0] WORDS_CAPACITY  = 8'd4;
  localparam logic [7:0] WORDS_SENSE     = 8'd9;

  // Configuration register indexes.
  localparam logic [1:0] REG_DISK0_PRESENT = 2'd0;
  localparam logic [1:0] REG_DISK0_BLOCKS  = 2'd1;
  localparam logic [1:0] REG_DISK1_PRESENT = 2'd2;
  localparam logic [1:0] REG_DISK1_BLOCKS  = 2'd3;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_READ       = 3'd1,
    ACT_WRITE      = 3'd2,
    ACT_CAPACITY   = 3'd3,
    ACT_SENSE      = 3'd4,
    ACT_INQUIRY    = 3'd5,
    ACT_MODE_SENSE = 3'd6
  } action_e;

  typedef struct packed {
    logic        disk0_present;
    logic [31:0] disk0_blocks;
    logic        disk1_present;
    logic [31:0] disk1_blocks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] target_id;
    logic [7:0] opcode;
    logic [7:0] cdb_byte1;
    logic [7:0] cdb_byte2;
    logic [7:0] cdb_byte3;
    logic [7:0] cdb_byte4;
    logic [7:0] cdb_byte5;
    logic [7:0] cdb_byte6;
    logic [7:0] cdb_byte7;
    logic [7:0] cdb_byte8;
  } cmd_t;

  typedef struct packed {
    logic        acknowledged;
    logic        check_condition;
    action_e     action;
    logic [31:0] transfer_lba;
    logic [15:0] transfer_blocks;
    logic [7:0]  response_words;
    logic [7:0]  reported_asc;
    logic        lun_absent;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [7:0] code;
  } sense_upd_t;

endpackage

@@ rtl/acsd_cfg_regs.sv @@
// Configuration registers: target presence bits and target sizes.
module acsd_cfg_regs import acsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DISK0_PRESENT: cfg_q.disk0_present <= cfg_wdata_i[0];
        REG_DISK0_BLOCKS:  cfg_q.disk0_blocks  <= cfg_wdata_i;
        REG_DISK1_PRESENT: cfg_q.disk1_present <= cfg_wdata_i[0];
        REG_DISK1_BLOCKS:  cfg_q.disk1_blocks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/acsd_decode.sv @@
// Single-pass command decode: status, data action, range check and sense update.
module acsd_decode import acsd_pkg::*; #(
  parameter int NUM_TARGETS = 2
) (
  input  cmd_t       cmd_i,
  input  cfg_t       cfg_i,
  input  logic [7:0] sense_i,
  output result_t    res_o,
  output sense_upd_t upd_o
);

  logic        present;
  logic [31:0] blocks;
  logic        lun_nz;
  logic [8:0]  len6;
  logic [31:0] lba;
  logic [15:0] cnt;
  logic [32:0] end_blk;
  logic        in_range;
  action_e     rw_act;

  always_comb begin
    present = 1'b0;
    blocks  = '0;
    if ({1'b0, cmd_i.target_id} < 4'(NUM_TARGETS)) begin
      if (cmd_i.target_id == 3'd0) begin
        present = cfg_i.disk0_present;
        blocks  = cfg_i.disk0_blocks;
      end else if (cmd_i.target_id == 3'd1) begin
        present = cfg_i.disk1_present;
        blocks  = cfg_i.disk1_blocks;
      end
    end
  end

  assign lun_nz = cmd_i.cdb_byte1[7:5] != 3'd0;
  assign len6   = (cmd_i.cdb_byte4 == 8'd0) ? 9'd256 : {1'b0, cmd_i.cdb_byte4};

  // The 10-byte forms carry a full 32-bit address and a 16-bit count.
  always_comb begin
    if (cmd_i.opcode == OP_READ10 || cmd_i.opcode == OP_WRITE10) begin
      lba = {cmd_i.cdb_byte2, cmd_i.cdb_byte3, cmd_i.cdb_byte4, cmd_i.cdb_byte5};
      cnt = {cmd_i.cdb_byte7, cmd_i.cdb_byte8};
    end else begin
      lba = {11'd0, cmd_i.cdb_byte1[4:0], cmd_i.cdb_byte2, cmd_i.cdb_byte3};
      cnt = {7'd0, len6};
    end
  end

  // One extra bit keeps the end address from wrapping.
  assign end_blk  = {1'b0, lba} + {17'd0, cnt};
  assign in_range = end_blk <= {1'b0, blocks};
  assign rw_act   = (cmd_i.opcode == OP_READ6 || cmd_i.opcode == OP_READ10) ?
                    ACT_READ : ACT_WRITE;

  always_comb begin
    res_o        = '0;
    res_o.action = ACT_NONE;
    upd_o        = '0;
    if (present) begin
      res_o.acknowledged = 1'b1;
      upd_o.we           = 1'b1;
      upd_o.code         = ASC_NONE;
      case (cmd_i.opcode)
        OP_TEST_READY, OP_FORMAT, OP_READ_CAP, OP_MODE_SENSE: begin
          if (lun_nz) begin
            upd_o.code            = ASC_LUN;
            res_o.check_condition = 1'b1;
          end else if (cmd_i.opcode == OP_READ_CAP) begin
            res_o.action         = ACT_CAPACITY;
            res_o.response_words = WORDS_CAPACITY;
          end else if (cmd_i.opcode == OP_MODE_SENSE) begin
            res_o.action         = ACT_MODE_SENSE;
            res_o.response_words = len6[8:1];
          end
        end
        OP_REQ_SENSE: begin
          // Reports the stored code (or the LUN error) and leaves it cleared.
          res_o.action         = ACT_SENSE;
          res_o.response_words = WORDS_SENSE;
          res_o.reported_asc   = lun_nz ? ASC_LUN : sense_i;
        end
        OP_READ6, OP_READ10, OP_WRITE6, OP_WRITE10: begin
          if (lun_nz) begin
            upd_o.code            = ASC_LUN;
            res_o.check_condition = 1'b1;
          end else if (in_range) begin
            res_o.action          = rw_act;
            res_o.transfer_lba    = lba;
            res_o.transfer_blocks = cnt;
          end else begin
            upd_o.code            = ASC_RANGE;
            res_o.check_condition = 1'b1;
          end
        end
        OP_INQUIRY: begin
          res_o.action         = ACT_INQUIRY;
          res_o.response_words = len6[8:1];
          res_o.lun_absent     = lun_nz;
        end
        default: begin
          upd_o.code            = ASC_OPCODE;
          res_o.check_condition = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/acsi_scsi_command_decoder.sv @@
// Top level of the hard-disk command decoder: channels, pipeline and sense store.
//
// The block decodes one command block per transfer on the input channel
// (target number, opcode and command bytes 1 to 8) and returns one status
// item per command on the output channel. Both channels use valid/ready;
// a transfer happens on a rising edge where valid and ready are both high.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must do so only while the block is idle (the block does not enforce
// this). Index 0/2: presence of targets zero/one; 1/3: sizes in 512-byte blocks.
// A command taken on the input channel lands in the input register, and its
// result is loaded into the output register once that is free or being emptied,
// raising out_valid_o. Throughput is one command per cycle unless the
// receiver stalls: the decode is a single pass of combinational logic between
// the two registers, with the 33-bit range add and compare as the longest path.
// The stored sense code of a target is updated on the same edge that loads
// the result, so the next command already sees it.
// When the receiver stalls, the result waits in the output register and one
// more command waits in the input register; only then does in_ready_o drop.
// Reset clears both valid flags, all configuration and the sense codes.
module acsi_scsi_command_decoder import acsd_pkg::*; #(
  parameter int NUM_TARGETS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // Command channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  target_id_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  cdb_byte1_i,
  input  logic [7:0]  cdb_byte2_i,
  input  logic [7:0]  cdb_byte3_i,
  input  logic [7:0]  cdb_byte4_i,
  input  logic [7:0]  cdb_byte5_i,
  input  logic [7:0]  cdb_byte6_i,
  input  logic [7:0]  cdb_byte7_i,
  input  logic [7:0]  cdb_byte8_i,
  // Status channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        acknowledged_o,
  output logic        check_condition_o,
  output logic [2:0]  action_o,
  output logic [31:0] transfer_lba_o,
  output logic [15:0] transfer_blocks_o,
  output logic [7:0]  response_words_o,
  output logic [7:0]  reported_asc_o,
  output logic        lun_absent_o
);

  // Only targets zero and one can ever be attached, so no more sense
  // entries are kept than that.
  localparam int NumSense = (NUM_TARGETS < 2) ? NUM_TARGETS : 2;

  cfg_t       cfg;
  cmd_t       s1_q;
  logic       s1_valid_q;
  result_t    out_q;
  logic       out_valid_q;
  logic       advance;
  logic [7:0] sense_q [NumSense];
  logic [7:0] sense_rd;
  result_t    dec_res;
  sense_upd_t dec_upd;

  acsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The input register moves on when the output register is free or is
  // being emptied in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= '{target_id: target_id_i, opcode: opcode_i,
                cdb_byte1: cdb_byte1_i, cdb_byte2: cdb_byte2_i,
                cdb_byte3: cdb_byte3_i, cdb_byte4: cdb_byte4_i,
                cdb_byte5: cdb_byte5_i, cdb_byte6: cdb_byte6_i,
                cdb_byte7: cdb_byte7_i, cdb_byte8: cdb_byte8_i};
    end
    if (advance) begin
      out_q <= dec_res;
    end
  end

  // Stored sense code of the addressed target.
  always_comb begin
    sense_rd = ASC_NONE;
    for (int i = 0; i < NumSense; i++) begin
      if (s1_q.target_id == 3'(i)) begin
        sense_rd = sense_q[i];
      end
    end
  end

  acsd_decode #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_decode (
    .cmd_i   (s1_q),
    .cfg_i   (cfg),
    .sense_i (sense_rd),
    .res_o   (dec_res),
    .upd_o   (dec_upd)
  );

  // An absent target never asks for a write, so the index is always in range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSense; i++) begin
        sense_q[i] <= ASC_NONE;
      end
    end else if (advance && dec_upd.we) begin
      for (int i = 0; i < NumSense; i++) begin
        if (s1_q.target_id == 3'(i)) begin
          sense_q[i] <= dec_upd.code;
        end
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign acknowledged_o    = out_q.acknowledged;
  assign check_condition_o = out_q.check_condition;
  assign action_o          = out_q.action;
  assign transfer_lba_o    = out_q.transfer_lba;
  assign transfer_blocks_o = out_q.transfer_blocks;
  assign response_words_o  = out_q.response_words;
  assign reported_asc_o    = out_q.reported_asc;
  assign lun_absent_o      = out_q.lun_absent;

  // A held command is not lost while the result register is blocked.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("command dropped from input register while stalled");

  // A check condition never starts a data phase.
  a_chk_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dec_res.check_condition) |-> (dec_res.action == ACT_NONE))
    else $error("check condition with nonzero action");

  // A nak carries no status and leaves the sense codes alone.
  a_nak_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !dec_res.acknowledged) |->
      (!dec_res.check_condition && !dec_upd.we))
    else $error("nak with status or sense update");

  // A good status for target zero leaves its stored code cleared.
  a_good_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dec_res.acknowledged && !dec_res.check_condition &&
     s1_q.target_id == 3'd0) |=> (sense_q[0] == ASC_NONE))
    else $error("sense code not cleared after good status");

  // A result is only loaded while the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule
